### rtl/core/dtlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drop-tail link buffer package
// Shared widths, register indexes, accounting commands and record types.
// ----------------------------------------------------------------------------
package dtlb_pkg;

  localparam int BufferDepth = 128;
  localparam int IdxW        = $clog2(BufferDepth);
  localparam int OccW        = $clog2(BufferDepth + 1);

  localparam int TimeW       = 48;
  localparam int BytesW      = 16;
  localparam int NpbW        = 20;
  localparam int LimitW      = 8;
  localparam int ProdW       = BytesW + NpbW;
  localparam int QBytesW     = $clog2(BufferDepth * 65535 + 1);
  localparam int PktCntW     = 32;
  localparam int ByteCntW    = 48;
  localparam int DelayW      = 40;
  localparam int DelaySumW   = 56;

  localparam int QPktOutW    = 8;
  localparam int QByteOutW   = 23;

  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 20;

  localparam logic [CfgIdxW-1:0] CfgNsPerByte   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBufferLimit = 1'b1;

  localparam logic [NpbW-1:0]   NsPerByteRst = 20'd1000;
  localparam logic [LimitW-1:0] LimitRst     = 8'd100;

  typedef enum logic [1:0] {
    AcctNone,
    AcctRetire,
    AcctDrop,
    AcctEnqueue
  } acct_op_e;

  typedef struct packed {
    acct_op_e            op;
    logic [BytesW-1:0]   bytes;
    logic [DelayW-1:0]   delay;
  } acct_cmd_t;

  typedef struct packed {
    logic [OccW-1:0]      occ_p;
    logic [QBytesW-1:0]   occ_b;
    logic [PktCntW-1:0]   sent_p;
    logic [ByteCntW-1:0]  sent_b;
    logic [PktCntW-1:0]   lost_p;
    logic [ByteCntW-1:0]  lost_b;
    logic [OccW-1:0]      peak_p;
    logic [QBytesW-1:0]   peak_b;
    logic [DelaySumW-1:0] delay_sum;
  } acct_stat_t;

  typedef struct packed {
    logic [TimeW-1:0]  dep;
    logic [BytesW-1:0] bytes;
    logic [DelayW-1:0] delay;
  } slot_t;

  typedef struct packed {
    logic       accepted;
    logic       dropped;
    acct_stat_t stat;
  } rsp_t;

endpackage

### rtl/core/dtlb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drop-tail link buffer channels
// Request channel (arrival or drain) and result channel with valid/ready.
// ----------------------------------------------------------------------------
interface dtlb_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [dtlb_pkg::TimeW-1:0]  arrival_time_ns;
  logic [dtlb_pkg::BytesW-1:0] packet_bytes;

  modport source (output valid, output action, output arrival_time_ns,
                  output packet_bytes, input ready);
  modport sink   (input valid, input action, input arrival_time_ns,
                  input packet_bytes, output ready);
endinterface

interface dtlb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic                          dropped;
  logic [dtlb_pkg::QPktOutW-1:0]  queued_packets;
  logic [dtlb_pkg::QByteOutW-1:0] queued_bytes;
  logic [dtlb_pkg::PktCntW-1:0]   delivered_packets;
  logic [dtlb_pkg::ByteCntW-1:0]  delivered_bytes;
  logic [dtlb_pkg::PktCntW-1:0]   lost_packets;
  logic [dtlb_pkg::ByteCntW-1:0]  lost_bytes;
  logic [dtlb_pkg::QPktOutW-1:0]  peak_packets;
  logic [dtlb_pkg::QByteOutW-1:0] peak_bytes;
  logic [dtlb_pkg::DelaySumW-1:0] total_delay_ns;

  modport source (output valid, output accepted, output dropped,
                  output queued_packets, output queued_bytes,
                  output delivered_packets, output delivered_bytes,
                  output lost_packets, output lost_bytes,
                  output peak_packets, output peak_bytes,
                  output total_delay_ns, input ready);
  modport sink   (input valid, input accepted, input dropped,
                  input queued_packets, input queued_bytes,
                  input delivered_packets, input delivered_bytes,
                  input lost_packets, input lost_bytes,
                  input peak_packets, input peak_bytes,
                  input total_delay_ns, output ready);
endinterface

### rtl/core/drop_tail_link_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drop-tail link buffer core
// Packet FIFO in front of a fixed-rate link with saturating statistics.
// ----------------------------------------------------------------------------
// Each accepted item first retires packets at the head (every queued one for
// a drain), then goes straight to the result when dropped or draining, or
// through StMul, StDep and StEnq when queued; no new request is taken until
// its result is registered. The head scan retires one slot per cycle through the registered memory port.
// Reset: asynchronous, clears queue pointers and counters, loads ns_per_byte
// 1000 and a limit of 100 packets; slot memory contents are not cleared.
module drop_tail_link_buffer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dtlb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dtlb_pkg::CfgDataW-1:0]   cfg_data_i,
  dtlb_req_if.sink                        req_i,
  dtlb_rsp_if.source                      rsp_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDep  = 3'd3;
  localparam logic [2:0] StEnq  = 3'd4;
  localparam logic [2:0] StResp = 3'd5;

  localparam int DepSumW = dtlb_pkg::TimeW + 1;

  logic [2:0]                     state_q, state_d;
  logic [dtlb_pkg::NpbW-1:0]      npb_q;
  logic [dtlb_pkg::LimitW-1:0]    limit_q;
  logic [dtlb_pkg::IdxW-1:0]      head_q, head_d;
  logic [dtlb_pkg::IdxW-1:0]      tail_q, tail_d;
  logic [dtlb_pkg::TimeW-1:0]     link_free_q, link_free_d;
  logic                           action_q;
  logic [dtlb_pkg::TimeW-1:0]     now_q;
  logic [dtlb_pkg::BytesW-1:0]    bytes_q;
  logic [dtlb_pkg::ProdW-1:0]     prod_q, prod_d;
  logic [dtlb_pkg::TimeW-1:0]     start_q, start_d;
  logic [dtlb_pkg::TimeW-1:0]     dep_q, dep_d;
  logic                           acc_q, acc_d;
  logic                           drop_q, drop_d;
  logic                           rsp_valid_q, rsp_valid_d;
  dtlb_pkg::rsp_t                 rsp_q, rsp_d;

  dtlb_pkg::acct_cmd_t            acct_cmd;
  dtlb_pkg::acct_stat_t           acct_stat;
  dtlb_pkg::slot_t                head_slot;
  dtlb_pkg::slot_t                new_slot;
  logic                           mem_we;

  logic [dtlb_pkg::OccW-1:0]      limit_eff;
  logic                           can_retire;
  logic [DepSumW-1:0]             dep_sum;
  logic [dtlb_pkg::TimeW-1:0]     dly_full;
  logic                           req_fire;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == StIdle);

  assign limit_eff = (32'(limit_q) > dtlb_pkg::BufferDepth)
                   ? dtlb_pkg::OccW'(dtlb_pkg::BufferDepth)
                   : dtlb_pkg::OccW'(limit_q);

  assign can_retire = (acct_stat.occ_p != '0) && (action_q || (head_slot.dep <= now_q));

  assign dep_sum  = {1'b0, start_q} + DepSumW'(prod_q);
  assign dly_full = dep_q - now_q;

  assign new_slot.dep   = dep_q;
  assign new_slot.bytes = bytes_q;
  assign new_slot.delay = (|dly_full[dtlb_pkg::TimeW-1:dtlb_pkg::DelayW])
                        ? '1 : dly_full[dtlb_pkg::DelayW-1:0];

  always_comb begin
    state_d        = state_q;
    head_d         = head_q;
    tail_d         = tail_q;
    link_free_d    = link_free_q;
    prod_d         = prod_q;
    start_d        = start_q;
    dep_d          = dep_q;
    acc_d          = acc_q;
    drop_d         = drop_q;
    rsp_d          = rsp_q;
    rsp_valid_d    = rsp_valid_q;
    mem_we         = 1'b0;
    acct_cmd.op    = dtlb_pkg::AcctNone;
    acct_cmd.bytes = head_slot.bytes;
    acct_cmd.delay = head_slot.delay;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (req_fire) begin
          acc_d   = 1'b0;
          drop_d  = 1'b0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (can_retire) begin
          acct_cmd.op = dtlb_pkg::AcctRetire;
          head_d = (head_q == dtlb_pkg::IdxW'(dtlb_pkg::BufferDepth - 1))
                 ? '0 : head_q + dtlb_pkg::IdxW'(1);
        end else if (action_q) begin
          state_d = StResp;
        end else if (acct_stat.occ_p < limit_eff) begin
          state_d = StMul;
        end else begin
          acct_cmd.op    = dtlb_pkg::AcctDrop;
          acct_cmd.bytes = bytes_q;
          drop_d         = 1'b1;
          state_d        = StResp;
        end
      end
      StMul: begin
        prod_d  = dtlb_pkg::ProdW'(bytes_q) * dtlb_pkg::ProdW'(npb_q);
        start_d = (now_q > link_free_q) ? now_q : link_free_q;
        state_d = StDep;
      end
      StDep: begin
        dep_d   = dep_sum[DepSumW-1] ? '1 : dep_sum[DepSumW-2:0];
        state_d = StEnq;
      end
      StEnq: begin
        mem_we         = 1'b1;
        tail_d         = (tail_q == dtlb_pkg::IdxW'(dtlb_pkg::BufferDepth - 1))
                       ? '0 : tail_q + dtlb_pkg::IdxW'(1);
        link_free_d    = dep_q;
        acct_cmd.op    = dtlb_pkg::AcctEnqueue;
        acct_cmd.bytes = bytes_q;
        acc_d          = 1'b1;
        state_d        = StResp;
      end
      StResp: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_d.accepted = acc_q;
          rsp_d.dropped  = drop_q;
          rsp_d.stat     = acct_stat;
          rsp_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      npb_q       <= dtlb_pkg::NsPerByteRst;
      limit_q     <= dtlb_pkg::LimitRst;
      head_q      <= '0;
      tail_q      <= '0;
      link_free_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      link_free_q <= link_free_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dtlb_pkg::CfgNsPerByte:   npb_q   <= cfg_data_i[dtlb_pkg::NpbW-1:0];
          dtlb_pkg::CfgBufferLimit: limit_q <= cfg_data_i[dtlb_pkg::LimitW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      action_q <= req_i.action;
      now_q    <= req_i.arrival_time_ns;
      bytes_q  <= req_i.packet_bytes;
    end
    prod_q  <= prod_d;
    start_q <= start_d;
    dep_q   <= dep_d;
    acc_q   <= acc_d;
    drop_q  <= drop_d;
    rsp_q   <= rsp_d;
  end

  dtlb_slot_mem u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (new_slot),
    .raddr_i (head_d),
    .rdata_o (head_slot)
  );

  dtlb_acct u_acct (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (acct_cmd),
    .stat_o (acct_stat)
  );

  assign rsp_o.valid             = rsp_valid_q;
  assign rsp_o.accepted          = rsp_q.accepted;
  assign rsp_o.dropped           = rsp_q.dropped;
  assign rsp_o.queued_packets    = dtlb_pkg::QPktOutW'(rsp_q.stat.occ_p);
  assign rsp_o.queued_bytes      = dtlb_pkg::QByteOutW'(rsp_q.stat.occ_b);
  assign rsp_o.delivered_packets = rsp_q.stat.sent_p;
  assign rsp_o.delivered_bytes   = rsp_q.stat.sent_b;
  assign rsp_o.lost_packets      = rsp_q.stat.lost_p;
  assign rsp_o.lost_bytes        = rsp_q.stat.lost_b;
  assign rsp_o.peak_packets      = dtlb_pkg::QPktOutW'(rsp_q.stat.peak_p);
  assign rsp_o.peak_bytes        = dtlb_pkg::QByteOutW'(rsp_q.stat.peak_b);
  assign rsp_o.total_delay_ns    = rsp_q.stat.delay_sum;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(acct_stat.occ_p) <= dtlb_pkg::BufferDepth)
    else $error("Occupancy exceeds the buffer depth.");

  a_retire_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acct_cmd.op == dtlb_pkg::AcctRetire) |-> (acct_stat.occ_p != '0))
    else $error("Retire issued on an empty queue.");

  a_enqueue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acct_cmd.op == dtlb_pkg::AcctEnqueue) |-> (acct_stat.occ_p < limit_eff))
    else $error("Enqueue issued without room under the limit.");

  a_empty_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acct_stat.occ_p == '0) |-> (acct_stat.occ_b == '0))
    else $error("Empty queue still holds bytes.");

  a_rsp_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(rsp_q.accepted && rsp_q.dropped))
    else $error("Result marks a packet both accepted and dropped.");
`endif

endmodule

### rtl/core/dtlb_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drop-tail link buffer slot memory
// One write port and one registered read port holding the queued packets.
// ----------------------------------------------------------------------------
module dtlb_slot_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [dtlb_pkg::IdxW-1:0]  waddr_i,
  input  dtlb_pkg::slot_t            wdata_i,
  input  logic [dtlb_pkg::IdxW-1:0]  raddr_i,
  output dtlb_pkg::slot_t            rdata_o
);

  dtlb_pkg::slot_t mem_q [dtlb_pkg::BufferDepth];
  dtlb_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/dtlb_acct.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drop-tail link buffer accounting unit
// Shared saturating adders that apply one retire, drop or enqueue per cycle.
// ----------------------------------------------------------------------------
module dtlb_acct (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dtlb_pkg::acct_cmd_t   cmd_i,
  output dtlb_pkg::acct_stat_t  stat_o
);

  localparam int CntSumW  = dtlb_pkg::PktCntW + 1;
  localparam int ByteSumW = dtlb_pkg::ByteCntW + 1;
  localparam int DlySumW  = dtlb_pkg::DelaySumW + 1;

  dtlb_pkg::acct_stat_t stat_q, stat_d;

  logic                           is_retire;
  logic [dtlb_pkg::PktCntW-1:0]   cnt_a;
  logic [CntSumW-1:0]             cnt_sum;
  logic [dtlb_pkg::PktCntW-1:0]   cnt_sat;
  logic [dtlb_pkg::ByteCntW-1:0]  byte_a;
  logic [ByteSumW-1:0]            byte_sum;
  logic [dtlb_pkg::ByteCntW-1:0]  byte_sat;
  logic [DlySumW-1:0]             dly_sum;
  logic [dtlb_pkg::DelaySumW-1:0] dly_sat;
  logic [dtlb_pkg::QBytesW-1:0]   occ_b_next;
  logic [dtlb_pkg::OccW-1:0]      occ_p_inc;

  assign is_retire = (cmd_i.op == dtlb_pkg::AcctRetire);
  assign cnt_a     = is_retire ? stat_q.sent_p : stat_q.lost_p;
  assign cnt_sum   = {1'b0, cnt_a} + CntSumW'(1);
  assign cnt_sat   = cnt_sum[CntSumW-1] ? '1 : cnt_sum[CntSumW-2:0];
  assign byte_a    = is_retire ? stat_q.sent_b : stat_q.lost_b;
  assign byte_sum  = {1'b0, byte_a} + ByteSumW'(cmd_i.bytes);
  assign byte_sat  = byte_sum[ByteSumW-1] ? '1 : byte_sum[ByteSumW-2:0];
  assign dly_sum   = {1'b0, stat_q.delay_sum} + DlySumW'(cmd_i.delay);
  assign dly_sat   = dly_sum[DlySumW-1] ? '1 : dly_sum[DlySumW-2:0];
  assign occ_b_next = is_retire
                    ? stat_q.occ_b - dtlb_pkg::QBytesW'(cmd_i.bytes)
                    : stat_q.occ_b + dtlb_pkg::QBytesW'(cmd_i.bytes);
  assign occ_p_inc = stat_q.occ_p + dtlb_pkg::OccW'(1);

  always_comb begin
    stat_d = stat_q;
    case (cmd_i.op)
      dtlb_pkg::AcctRetire: begin
        stat_d.sent_p    = cnt_sat;
        stat_d.sent_b    = byte_sat;
        stat_d.delay_sum = dly_sat;
        stat_d.occ_p     = stat_q.occ_p - dtlb_pkg::OccW'(1);
        stat_d.occ_b     = occ_b_next;
      end
      dtlb_pkg::AcctDrop: begin
        stat_d.lost_p = cnt_sat;
        stat_d.lost_b = byte_sat;
      end
      dtlb_pkg::AcctEnqueue: begin
        stat_d.occ_p = occ_p_inc;
        stat_d.occ_b = occ_b_next;
        if (occ_p_inc > stat_q.peak_p) begin
          stat_d.peak_p = occ_p_inc;
        end
        if (occ_b_next > stat_q.peak_b) begin
          stat_d.peak_b = occ_b_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
    end else begin
      stat_q <= stat_d;
    end
  end

  assign stat_o = stat_q;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drop-tail link buffer testbench
// Sends arrival and drain requests to the core with random gaps and stalls,
// predicts every result with a cycle-free queue model and checks the
// occupancy, delivery, loss, peak and delay statistics field by field.
// ----------------------------------------------------------------------------
module testbench;
  import dtlb_pkg::*;

  localparam logic ActArrive = 1'b0;
  localparam logic ActDrain  = 1'b1;

  localparam int IdleLimit   = 4000;
  localparam int HoldCycles  = 300;
  localparam int HoldAfter   = 400;
  localparam int ReportLimit = 200;

  localparam longint unsigned Max32 = 64'hFFFF_FFFF;
  localparam longint unsigned Max40 = 64'hFF_FFFF_FFFF;
  localparam longint unsigned Max48 = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned Max56 = 64'hFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic              action;
    logic [TimeW-1:0]  arrival_ns;
    logic [BytesW-1:0] nbytes;
  } link_req_t;

  typedef struct packed {
    logic                 accepted;
    logic                 dropped;
    logic [QPktOutW-1:0]  queued_packets;
    logic [QByteOutW-1:0] queued_bytes;
    logic [PktCntW-1:0]   delivered_packets;
    logic [ByteCntW-1:0]  delivered_bytes;
    logic [PktCntW-1:0]   lost_packets;
    logic [ByteCntW-1:0]  lost_bytes;
    logic [QPktOutW-1:0]  peak_packets;
    logic [QByteOutW-1:0] peak_bytes;
    logic [DelaySumW-1:0] total_delay_ns;
  } link_stats_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dtlb_req_if req_bus ();
  dtlb_rsp_if rsp_bus ();

  drop_tail_link_buffer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  // Queue model state.
  logic [TimeW-1:0]  depart_ns [BufferDepth];
  logic [BytesW-1:0] slot_len  [BufferDepth];
  logic [DelayW-1:0] slot_wait [BufferDepth];
  int                head_slot;
  int                tail_slot;
  int                held_pkts;
  int                peak_pkts;
  longint unsigned   held_bytes;
  longint unsigned   peak_held_bytes;
  longint unsigned   link_free_ns;
  longint unsigned   sent_pkts;
  longint unsigned   sent_bytes;
  longint unsigned   lost_pkts;
  longint unsigned   lost_bytes;
  longint unsigned   delay_total;
  int unsigned       npb_reg;
  int unsigned       limit_reg;

  link_req_t   pending_q [$];
  link_stats_t expected_q [$];
  link_req_t   cur_req;
  bit          offering;
  int unsigned send_gap;
  int unsigned issued;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned idle_cycles;
  longint unsigned now_ns;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned sat_add(input longint unsigned a,
                                              input longint unsigned b,
                                              input longint unsigned top);
    if (a >= top || b > top - a) begin
      return top;
    end
    return a + b;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_bytes();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return 0;
    end else if (r < 10) begin
      return 65535;
    end else if (r < 70) begin
      return $urandom_range(1, 1500);
    end else if (r < 90) begin
      return $urandom_range(1, 9000);
    end
    return $urandom_range(0, 65535);
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= ReportLimit) begin
      $display("ERROR at %0t: result %0d: %s", $time, results_seen, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  task automatic retire_oldest();
    sent_pkts   = sat_add(sent_pkts, 1, Max32);
    sent_bytes  = sat_add(sent_bytes, 64'(slot_len[head_slot]), Max48);
    delay_total = sat_add(delay_total, 64'(slot_wait[head_slot]), Max56);
    held_pkts--;
    held_bytes -= 64'(slot_len[head_slot]);
    head_slot = (head_slot + 1) % BufferDepth;
  endtask

  task automatic predict_step(input link_req_t rq);
    link_stats_t     r;
    longint unsigned arrive;
    longint unsigned start;
    longint unsigned dep;
    longint unsigned dly;
    int              cap;
    r = '0;
    arrive = 64'(rq.arrival_ns);
    if (rq.action == ActDrain) begin
      while (held_pkts > 0) retire_oldest();
    end else begin
      cap = (limit_reg > BufferDepth) ? BufferDepth : int'(limit_reg);
      while (held_pkts > 0 && 64'(depart_ns[head_slot]) <= arrive) retire_oldest();
      if (held_pkts < cap) begin
        start = (arrive > link_free_ns) ? arrive : link_free_ns;
        dep = start + 64'(rq.nbytes) * 64'(npb_reg);
        if (dep > Max48) begin
          dep = Max48;
        end
        dly = dep - arrive;
        if (dly > Max40) begin
          dly = Max40;
        end
        depart_ns[tail_slot] = dep[TimeW-1:0];
        slot_len[tail_slot]  = rq.nbytes;
        slot_wait[tail_slot] = dly[DelayW-1:0];
        tail_slot = (tail_slot + 1) % BufferDepth;
        link_free_ns = dep;
        held_pkts++;
        held_bytes += 64'(rq.nbytes);
        if (held_pkts > peak_pkts) begin
          peak_pkts = held_pkts;
        end
        if (held_bytes > peak_held_bytes) begin
          peak_held_bytes = held_bytes;
        end
        r.accepted = 1'b1;
      end else begin
        lost_pkts  = sat_add(lost_pkts, 1, Max32);
        lost_bytes = sat_add(lost_bytes, 64'(rq.nbytes), Max48);
        r.dropped  = 1'b1;
      end
    end
    r.queued_packets    = QPktOutW'(held_pkts);
    r.queued_bytes      = QByteOutW'(held_bytes);
    r.delivered_packets = PktCntW'(sent_pkts);
    r.delivered_bytes   = ByteCntW'(sent_bytes);
    r.lost_packets      = PktCntW'(lost_pkts);
    r.lost_bytes        = ByteCntW'(lost_bytes);
    r.peak_packets      = QPktOutW'(peak_pkts);
    r.peak_bytes        = QByteOutW'(peak_held_bytes);
    r.total_delay_ns    = DelaySumW'(delay_total);
    expected_q.push_back(r);
  endtask

  task automatic push_req(input logic act, input longint unsigned t,
                          input int unsigned b);
    link_req_t rq;
    rq.action     = act;
    rq.arrival_ns = t[TimeW-1:0];
    rq.nbytes     = b[BytesW-1:0];
    pending_q.push_back(rq);
  endtask

  task automatic push_drain();
    push_req(ActDrain, {16'($urandom), 32'($urandom)}, $urandom_range(0, 65535));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(val);
    case (idx)
      CfgNsPerByte: begin
        npb_reg = val & 32'hF_FFFF;
      end
      CfgBufferLimit: begin
        limit_reg = val & 32'hFF;
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    while (pending_q.size() != 0 || offering || expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (link_free_ns > now_ns) begin
      now_ns = link_free_ns;
    end
  endtask

  task automatic set_link(input int unsigned npb, input int unsigned lim);
    settle();
    write_reg(CfgNsPerByte, npb);
    write_reg(CfgBufferLimit, lim);
  endtask

  task automatic queue_traffic(input int n);
    longint unsigned svc;
    longint unsigned back;
    int unsigned     r;
    int unsigned     cap;
    svc = (npb_reg == 0) ? 50 : 64'(npb_reg) * 800;
    cap = (limit_reg > BufferDepth) ? BufferDepth : limit_reg;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        push_drain();
      end else begin
        if (r < 20) begin
          back = 0;
        end else if (r < 85) begin
          now_ns += 64'($urandom_range(0, 32'(2 * svc)));
        end else if (r < 95) begin
          now_ns += svc * 64'(cap) * 64'($urandom_range(1, 3));
        end else begin
          back = 64'($urandom_range(0, 32'(svc)));
          now_ns -= (now_ns < back) ? now_ns : back;
        end
        if (now_ns > Max48) begin
          now_ns = Max48;
        end
        push_req(ActArrive, now_ns, pick_bytes());
      end
    end
  endtask

  task automatic queue_burst(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 149) begin
        push_drain();
      end else begin
        push_req(ActArrive, now_ns, $urandom_range(30000, 65535));
      end
    end
  endtask

  task automatic queue_late(input int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_drain();
      end else if (r < 13) begin
        push_req(ActArrive, Max48, pick_bytes());
      end else begin
        push_req(ActArrive, {16'($urandom_range(32768, 65535)), 32'($urandom)},
                 pick_bytes());
      end
    end
  endtask

  // Request driver.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!offering) begin
      if (send_gap > 0) begin
        send_gap--;
        req_bus.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_req = pending_q.pop_front();
        req_bus.valid           <= 1'b1;
        req_bus.action          <= cur_req.action;
        req_bus.arrival_time_ns <= cur_req.arrival_ns;
        req_bus.packet_bytes    <= cur_req.nbytes;
        offering = 1'b1;
        issued++;
        send_gap = (issued % 300 < 60) ? 0 : pick_gap();
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && req_bus.valid && req_bus.ready) begin
      predict_step(cur_req);
      offering = 1'b0;
    end
  end

  // Result receiver with random stalls and one long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
      if (results_seen % 250 < 200 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    link_stats_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        check_field("accepted", 64'(rsp_bus.accepted), 64'(want.accepted));
        check_field("dropped", 64'(rsp_bus.dropped), 64'(want.dropped));
        check_field("queued_packets", 64'(rsp_bus.queued_packets),
                    64'(want.queued_packets));
        check_field("queued_bytes", 64'(rsp_bus.queued_bytes), 64'(want.queued_bytes));
        check_field("delivered_packets", 64'(rsp_bus.delivered_packets),
                    64'(want.delivered_packets));
        check_field("delivered_bytes", 64'(rsp_bus.delivered_bytes),
                    64'(want.delivered_bytes));
        check_field("lost_packets", 64'(rsp_bus.lost_packets), 64'(want.lost_packets));
        check_field("lost_bytes", 64'(rsp_bus.lost_bytes), 64'(want.lost_bytes));
        check_field("peak_packets", 64'(rsp_bus.peak_packets), 64'(want.peak_packets));
        check_field("peak_bytes", 64'(rsp_bus.peak_bytes), 64'(want.peak_bytes));
        check_field("total_delay_ns", 64'(rsp_bus.total_delay_ns),
                    64'(want.total_delay_ns));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgNsPerByte;
    cfg_data_i = '0;
    req_bus.valid           = 1'b0;
    req_bus.action          = ActArrive;
    req_bus.arrival_time_ns = '0;
    req_bus.packet_bytes    = '0;
    rsp_bus.ready           = 1'b0;
    head_slot       = 0;
    tail_slot       = 0;
    held_pkts       = 0;
    peak_pkts       = 0;
    held_bytes      = 0;
    peak_held_bytes = 0;
    link_free_ns    = 0;
    sent_pkts       = 0;
    sent_bytes      = 0;
    lost_pkts       = 0;
    lost_bytes      = 0;
    delay_total     = 0;
    npb_reg         = 32'(NsPerByteRst);
    limit_reg       = 32'(LimitRst);
    offering        = 1'b0;
    send_gap        = 0;
    issued          = 0;
    stall_left      = 0;
    hold_left       = 0;
    hold_done       = 1'b0;
    results_seen    = 0;
    error_count     = 0;
    idle_cycles     = 0;
    now_ns          = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero-length and largest packets, time running backwards, drains.
    push_req(ActArrive, 0, 0);
    push_req(ActArrive, 0, 65535);
    push_req(ActArrive, 5, 1);
    push_req(ActArrive, 3, 100);
    push_req(ActDrain, Max48, 65535);
    push_req(ActDrain, 0, 0);
    push_req(ActArrive, 100_000_000, 1500);
    push_req(ActArrive, 100_000_000, 1500);
    push_req(ActArrive, 200_000_000, 40);
    settle();
    write_reg(CfgBufferLimit, 0);
    push_req(ActArrive, 300_000_000, 777);
    push_req(ActArrive, 300_000_000, 65535);
    set_link(0, 1);
    push_req(ActArrive, 400_000_000, 500);
    push_req(ActArrive, 400_000_000, 9);
    push_req(ActArrive, 400_000_001, 0);
    push_req(ActDrain, 0, 0);
    set_link(2, 1);
    push_req(ActArrive, 500_000_000, 1000);
    push_req(ActArrive, 500_000_010, 5);
    push_req(ActArrive, 500_002_000, 3);

    set_link(1000, 100);
    queue_traffic(300);
    set_link(1, 4);
    queue_traffic(300);
    set_link(0, 128);
    queue_traffic(200);
    set_link($urandom_range(1, 1000000), $urandom_range(1, 128));
    queue_traffic(300);
    set_link(7, 2);
    queue_traffic(200);
    set_link(20'hF_FFFF, 255);
    queue_burst(200);
    set_link(1000, 64);
    queue_late(300);
    settle();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
